@@ design/tvs_pkg.sv @@
// Shared types and constants of the trilinear voxel sampler.
// Used by every module of the block but tvs_fifo; depends on nothing.
package tvs_pkg;

  localparam int DIM_MAX_DEF   = 32;
  localparam int FRAMES_DEF    = 2;
  localparam int FRAC_BITS_DEF = 8;

  localparam int COORD_W   = 14;
  localparam int VOX_W     = 16;
  localparam int RES_W     = 17;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_VOXEL_SIGNED
  } cfg_reg_t;

  // control part of one queued command
  typedef struct packed {
    logic       is_sample;
    logic       keep;      // write lands inside the volume
    logic [1:0] ins_x;     // {upper, lower} neighbor inside along x
    logic [1:0] ins_y;
    logic [1:0] ins_z;
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN,
    BK_PREP,
    BK_DIV,
    BK_ROUND,
    BK_OUT
  } bk_state_t;

endpackage

@@ design/tvs_fifo.sv @@
// Short command queue between the front and the back of the sampler.
// Depends on nothing but its parameters.
module tvs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/tvs_front.sv @@
// Front of the sampler: splits coordinates into cell index and fraction
// and classifies each neighbor as inside or outside. Uses tvs_pkg.
module tvs_front #(
  parameter int DIM_MAX   = tvs_pkg::DIM_MAX_DEF,
  parameter int FRAMES    = tvs_pkg::FRAMES_DEF,
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF,
  parameter int DW        = 5,
  parameter int FW        = 1,
  parameter int DATA_W    = 8
) (
  input  logic                                kind,
  input  logic signed [tvs_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [tvs_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [tvs_pkg::COORD_W-1:0]  coord_z,
  input  logic                                frame,
  input  logic [tvs_pkg::VOX_W-1:0]           voxel_value,
  input  logic [tvs_pkg::SIZE_W-1:0]          size_x,
  input  logic [tvs_pkg::SIZE_W-1:0]          size_y,
  input  logic [tvs_pkg::SIZE_W-1:0]          size_z,
  output tvs_pkg::cmd_ctl_t                   ctl,
  output logic [DATA_W-1:0]                   data
);

  localparam int EW    = (tvs_pkg::COORD_W > FRAC_BITS + 1) ? tvs_pkg::COORD_W + 1
                                                            : FRAC_BITS + 2;
  localparam int BW    = EW - FRAC_BITS;
  localparam int LIM_W = ($clog2(DIM_MAX + 1) > tvs_pkg::SIZE_W) ? $clog2(DIM_MAX + 1)
                                                                 : tvs_pkg::SIZE_W;
  localparam int CMPW  = ((BW + 1 > LIM_W) ? BW + 1 : LIM_W) + 1;

  logic signed [tvs_pkg::COORD_W-1:0] crd [3];
  logic [tvs_pkg::SIZE_W-1:0]         sz  [3];
  logic [1:0]                         ins [3];
  logic [DW-1:0]                      idx_lo [3];
  logic [DW-1:0]                      idx_hi [3];
  logic [FRAC_BITS-1:0]               frc [3];
  logic                               frame_ok;

  assign crd[0] = coord_x;
  assign crd[1] = coord_y;
  assign crd[2] = coord_z;
  assign sz[0]  = size_x;
  assign sz[1]  = size_y;
  assign sz[2]  = size_z;

  // per axis: floor index, fraction and range check of both neighbors
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [EW-1:0] ext;
    logic signed [BW-1:0] base;
    logic signed [BW:0]   hi;
    logic [LIM_W-1:0]     lim;

    assign ext    = EW'(crd[a]);
    assign base   = $signed(ext[EW-1:FRAC_BITS]);
    assign hi     = $signed({base[BW-1], base}) + $signed((BW + 1)'(1));
    assign frc[a] = ext[FRAC_BITS-1:0];
    assign lim    = (int'(sz[a]) > DIM_MAX) ? LIM_W'(DIM_MAX) : LIM_W'(sz[a]);

    assign ins[a][0] = !base[BW-1] && (CMPW'($unsigned(base)) < CMPW'(lim));
    assign ins[a][1] = !hi[BW] && (CMPW'($unsigned(hi)) < CMPW'(lim));
    assign idx_lo[a] = DW'($unsigned(base));
    assign idx_hi[a] = DW'($unsigned(hi));
  end

  assign frame_ok = (int'(frame) < FRAMES);

  // classify: a frame outside the store leaves no neighbor inside
  always_comb begin
    ctl.is_sample = kind;
    ctl.keep      = !kind && frame_ok && ins[0][0] && ins[1][0] && ins[2][0];
    ctl.ins_x     = frame_ok ? ins[0] : 2'b00;
    ctl.ins_y     = frame_ok ? ins[1] : 2'b00;
    ctl.ins_z     = frame_ok ? ins[2] : 2'b00;
  end

  assign data = {FW'(frame), voxel_value,
                 idx_hi[2], idx_hi[1], idx_hi[0],
                 idx_lo[2], idx_lo[1], idx_lo[0],
                 frc[2], frc[1], frc[0]};

endmodule

@@ design/tvs_back.sv @@
// Back of the sampler: voxel memory, weighted accumulation over the eight
// neighbors, bit-serial division with rounding and the result register.
// Uses tvs_pkg.
module tvs_back #(
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF,
  parameter int DW        = 5,
  parameter int FW        = 1,
  parameter int DATA_W    = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  tvs_pkg::cmd_ctl_t                  cmd_ctl,
  input  logic [DATA_W-1:0]                  cmd_data,
  output logic                               cmd_pop,
  input  logic                               voxel_signed,
  output logic                               out_valid,
  output logic signed [tvs_pkg::RES_W-1:0]   out_value,
  output logic                               out_in_domain,
  input  logic                               out_pop
);

  localparam int AW   = FW + 3 * DW;
  localparam int DEPTH = 1 << AW;
  localparam int FB   = FRAC_BITS;
  localparam int WXY  = 2 * FB + 2;
  localparam int WW   = 3 * FB + 1;
  localparam int SUW  = WW + tvs_pkg::VOX_W;
  localparam int QW   = tvs_pkg::RES_W;
  localparam int BIW  = $clog2(QW);

  tvs_pkg::bk_state_t st, st_next;

  // voxel memory
  logic [tvs_pkg::VOX_W-1:0] mem [DEPTH];
  logic [tvs_pkg::VOX_W-1:0] rdata;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic                      mem_we;

  // current command
  tvs_pkg::cmd_ctl_t   cur_ctl;
  logic [DATA_W-1:0]   cur_data;

  // fields of a command
  logic [FW-1:0]             f_frame, c_frame;
  logic [tvs_pkg::VOX_W-1:0] f_value, c_value;
  logic [DW-1:0]             f_lo [3];
  logic [DW-1:0]             f_hi [3];
  logic [DW-1:0]             c_lo [3];
  logic [DW-1:0]             c_hi [3];
  logic [FB-1:0]             c_frc [3];
  logic [FB-1:0]             f_frc [3];

  // sequencing and pipeline
  logic [2:0]      nb;
  logic [1:0]      dcnt;
  logic            s1_v, s2_v, s3_v;
  logic [WXY-1:0]  s1_wxy;
  logic [FB:0]     s1_wz;
  logic [WW-1:0]   s2_w, s3_w;
  logic [tvs_pkg::VOX_W-1:0] s2_u;
  logic [SUW-1:0]  s3_p;
  logic [WW-1:0]   sum_w;
  logic [SUW-1:0]  sum_u;
  logic [SUW-1:0]  rem;
  logic [QW-1:0]   quo;
  logic [BIW-1:0]  bi;
  logic            neg;
  logic signed [QW-1:0] res;

  logic [FB:0]     wgt [3];
  logic [DW-1:0]   sel [3];
  logic            nb_in;
  logic [SUW-1:0]  bias;
  logic [SUW-1:0]  shd;
  logic            any_in;
  logic            round_up;
  logic [QW-1:0]   mag;

  assign {f_frame, f_value, f_hi[2], f_hi[1], f_hi[0], f_lo[2], f_lo[1], f_lo[0],
          f_frc[2], f_frc[1], f_frc[0]} = cmd_data;
  assign {c_frame, c_value, c_hi[2], c_hi[1], c_hi[0], c_lo[2], c_lo[1], c_lo[0],
          c_frc[2], c_frc[1], c_frc[0]} = cur_data;

  // neighbor nb: bit 2 picks x, bit 1 picks y, bit 0 picks z
  for (genvar a = 0; a < 3; a++) begin : g_sel
    assign sel[a] = nb[2 - a] ? c_hi[a] : c_lo[a];
    assign wgt[a] = nb[2 - a] ? (FB + 1)'(c_frc[a])
                              : ((FB + 1)'(1) << FB) - (FB + 1)'(c_frc[a]);
  end

  assign nb_in = cur_ctl.ins_x[nb[2]] && cur_ctl.ins_y[nb[1]] && cur_ctl.ins_z[nb[0]];
  assign raddr = {c_frame, sel[2], sel[1], sel[0]};
  assign waddr = {f_frame, f_lo[2], f_lo[1], f_lo[0]};
  assign any_in = (|cur_ctl.ins_x) && (|cur_ctl.ins_y) && (|cur_ctl.ins_z);
  assign bias  = voxel_signed ? (SUW'(sum_w) << (tvs_pkg::VOX_W - 1)) : '0;
  assign shd   = SUW'(sum_w) << bi;
  assign round_up = (rem >= (SUW'(sum_w) - rem));
  assign mag   = quo + QW'(round_up);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= f_value;
    end
    rdata <= mem[raddr];
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      tvs_pkg::BK_IDLE: begin
        if (cmd_valid && cmd_ctl.is_sample) st_next = tvs_pkg::BK_ISSUE;
      end
      tvs_pkg::BK_ISSUE: begin
        if (nb == 3'd7) st_next = tvs_pkg::BK_DRAIN;
      end
      tvs_pkg::BK_DRAIN: begin
        if (dcnt == 2'd2) st_next = tvs_pkg::BK_PREP;
      end
      tvs_pkg::BK_PREP:  st_next = tvs_pkg::BK_DIV;
      tvs_pkg::BK_DIV: begin
        if (bi == '0) st_next = tvs_pkg::BK_ROUND;
      end
      tvs_pkg::BK_ROUND: st_next = tvs_pkg::BK_OUT;
      tvs_pkg::BK_OUT: begin
        if (!out_valid || out_pop) st_next = tvs_pkg::BK_IDLE;
      end
      default: st_next = tvs_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop = 1'b0;
    mem_we  = 1'b0;
    unique case (st)
      tvs_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
        mem_we  = cmd_valid && !cmd_ctl.is_sample && cmd_ctl.keep;
      end
      default: begin
        cmd_pop = 1'b0;
        mem_we  = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= tvs_pkg::BK_IDLE;
      out_valid <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
    end else begin
      st   <= st_next;
      s1_v <= (st == tvs_pkg::BK_ISSUE) && nb_in;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (st == tvs_pkg::BK_OUT && (!out_valid || out_pop)) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // weight pipeline: axis pair, full weight, weighted voxel
    s1_wxy <= WXY'(wgt[0]) * WXY'(wgt[1]);
    s1_wz  <= wgt[2];
    s2_w   <= WW'((WXY + FB + 1)'(s1_wxy) * (WXY + FB + 1)'(s1_wz));
    s2_u   <= voxel_signed ? (rdata ^ 16'h8000) : rdata;
    s3_w   <= s2_w;
    s3_p   <= SUW'(s2_w) * SUW'(s2_u);

    unique case (st)
      tvs_pkg::BK_IDLE: begin
        if (cmd_valid && cmd_ctl.is_sample) begin
          cur_ctl  <= cmd_ctl;
          cur_data <= cmd_data;
        end
        nb    <= '0;
        dcnt  <= '0;
        sum_w <= '0;
        sum_u <= '0;
      end
      tvs_pkg::BK_ISSUE: begin
        nb <= nb + 3'd1;
      end
      tvs_pkg::BK_PREP: begin
        neg <= (sum_u < bias);
        rem <= (sum_u >= bias) ? sum_u - bias : bias - sum_u;
        quo <= '0;
        bi  <= BIW'(QW - 1);
      end
      tvs_pkg::BK_DIV: begin
        if (rem >= shd) begin
          rem     <= rem - shd;
          quo[bi] <= 1'b1;
        end
        bi <= bi - BIW'(1);
      end
      tvs_pkg::BK_ROUND: begin
        if (any_in && sum_w != '0) begin
          res <= neg ? -$signed(mag) : $signed(mag);
        end else begin
          res <= '0;
        end
      end
      default: begin
      end
    endcase

    if (st == tvs_pkg::BK_DRAIN) begin
      dcnt <= dcnt + 2'd1;
    end
    // accumulate a kept neighbor
    if (s3_v) begin
      sum_w <= sum_w + s3_w;
      sum_u <= sum_u + s3_p;
    end
    // load the result register
    if (st == tvs_pkg::BK_OUT && (!out_valid || out_pop)) begin
      out_value     <= res;
      out_in_domain <= any_in;
    end
  end

endmodule

@@ design/trilinear_voxel_sampler.sv @@
// A sample passes queue handoff, memory reads of its eight neighbors, drain,
// divider setup, 17 quotient bits, rounding and output. No new sample starts
// before the last is through, set by the one read port of the voxel memory
// and the one-bit-per-cycle divider; writes are taken only while idle.
// Reset: queue, sequencer and result flag clear; sizes return to 32 and
// voxels to signed. The voxel memory is not cleared.
module trilinear_voxel_sampler #(
  parameter int DIM_MAX   = tvs_pkg::DIM_MAX_DEF,
  parameter int FRAMES    = tvs_pkg::FRAMES_DEF,
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                kind,
  input  logic signed [tvs_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [tvs_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [tvs_pkg::COORD_W-1:0]  coord_z,
  input  logic                                frame,
  input  logic [tvs_pkg::VOX_W-1:0]           voxel_value,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [tvs_pkg::RES_W-1:0]    sample_value,
  output logic                                in_domain,
  input  logic                                cfg_we,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvs_pkg::SIZE_W-1:0]          cfg_data
);

  localparam int DW     = $clog2(DIM_MAX);
  localparam int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int DATA_W = FW + tvs_pkg::VOX_W + 6 * DW + 3 * FRAC_BITS;
  localparam int QDW    = tvs_pkg::CTL_W + DATA_W;

  logic [tvs_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic                       voxel_signed;

  tvs_pkg::cmd_ctl_t  f_ctl, b_ctl;
  logic [DATA_W-1:0]  f_data, b_data;
  logic [QDW-1:0]     q_rdata;
  logic               q_empty;
  logic               q_pop;
  logic               out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x       <= tvs_pkg::SIZE_W'(32);
      size_y       <= tvs_pkg::SIZE_W'(32);
      size_z       <= tvs_pkg::SIZE_W'(32);
      voxel_signed <= 1'b1;
    end else if (cfg_we) begin
      unique case (tvs_pkg::cfg_reg_t'(cfg_index))
        tvs_pkg::REG_SIZE_X:       size_x       <= cfg_data;
        tvs_pkg::REG_SIZE_Y:       size_y       <= cfg_data;
        tvs_pkg::REG_SIZE_Z:       size_z       <= cfg_data;
        tvs_pkg::REG_VOXEL_SIGNED: voxel_signed <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tvs_front #(
    .DIM_MAX(DIM_MAX), .FRAMES(FRAMES), .FRAC_BITS(FRAC_BITS),
    .DW(DW), .FW(FW), .DATA_W(DATA_W)
  ) u_front (
    .kind(kind), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .frame(frame), .voxel_value(voxel_value),
    .size_x(size_x), .size_y(size_y), .size_z(size_z),
    .ctl(f_ctl), .data(f_data)
  );

  tvs_fifo #(.W(QDW), .DEPTH(tvs_pkg::CMD_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .wdata({f_ctl, f_data}), .full(full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  assign {b_ctl, b_data} = q_rdata;

  tvs_back #(
    .FRAC_BITS(FRAC_BITS), .DW(DW), .FW(FW), .DATA_W(DATA_W)
  ) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(!q_empty), .cmd_ctl(b_ctl), .cmd_data(b_data), .cmd_pop(q_pop),
    .voxel_signed(voxel_signed),
    .out_valid(out_valid), .out_value(sample_value), .out_in_domain(in_domain),
    .out_pop(pop)
  );

  assign empty = !out_valid;

endmodule

@@ design/tvs_check.sv @@
// Port-level checks of the trilinear voxel sampler, bound to its top level.
// Depends on tvs_pkg and trilinear_voxel_sampler.
module tvs_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [tvs_pkg::RES_W-1:0]  sample_value,
  input logic                              in_domain
);

  // reset leaves the command queue open and the result side empty
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue state wrong after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(sample_value) && $stable(in_domain))
    else $error("waiting result changed");

  // outside the domain the value is zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !in_domain |-> sample_value == '0)
    else $error("nonzero value outside domain");

  // a value never falls below the signed voxel range
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(sample_value[16] && !sample_value[15]))
    else $error("value below voxel range");

endmodule

bind trilinear_voxel_sampler tvs_check u_check (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for trilinear_voxel_sampler: voxel loads, directed and random samples.
// Depends on tvs_pkg and the trilinear_voxel_sampler RTL; reads no files.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_MAX_DEF   = tvs_pkg::DIM_MAX_DEF;
  localparam int FRAMES_DEF    = tvs_pkg::FRAMES_DEF;
  localparam int FRAC_BITS_DEF = tvs_pkg::FRAC_BITS_DEF;
  localparam int COORD_W       = tvs_pkg::COORD_W;
  localparam int VOX_W         = tvs_pkg::VOX_W;
  localparam int RES_W         = tvs_pkg::RES_W;
  localparam int SIZE_W        = tvs_pkg::SIZE_W;
  localparam int CFG_IDX_W     = tvs_pkg::CFG_IDX_W;

  localparam int DIM       = DIM_MAX_DEF;
  localparam int ONE       = 1 << FRAC_BITS_DEF;
  localparam int DRAIN_CYC = 64;
  localparam int HOLD_CYC  = 400;
  localparam int PER_PHASE = 220;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic                      kind = 1'b0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic                      frame = 1'b0;
  logic [VOX_W-1:0]          voxel_value = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [RES_W-1:0]   sample_value;
  logic                      in_domain;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = tvs_pkg::REG_SIZE_X;
  logic [SIZE_W-1:0]         cfg_data = '0;

  trilinear_voxel_sampler dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL trilinear_voxel_sampler");
    $finish;
  end

  // Expected sample results, oldest first
  typedef struct {
    logic [RES_W-1:0] value;
    logic             dom;
  } sample_res_t;

  sample_res_t       pending_samples[$];
  int                errors = 0;
  int                sent_items = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                hold_req = 1'b0;

  // Shadow volume and configuration
  logic [VOX_W-1:0]  vox_mem [DIM*DIM*DIM*FRAMES_DEF];
  bit                vox_set [DIM*DIM*DIM*FRAMES_DEF];
  logic [SIZE_W-1:0] sz [3];
  bit                vox_signed;

  function automatic int vox_addr(int x, int y, int z, int f);
    return ((f * DIM + z) * DIM + y) * DIM + x;
  endfunction

  function automatic int eff_lim(int a);
    return (sz[a] > DIM) ? DIM : int'(sz[a]);
  endfunction

  function automatic bit on_grid(int a, int i);
    return (i >= 0) && (i < eff_lim(a));
  endfunction

  // Trilinear sum over the kept neighbors, normalized and rounded half away from zero
  function automatic sample_res_t interpolate(int cx, int cy, int cz, int f);
    int                 c [3];
    int                 base [3];
    longint unsigned    fr [3];
    longint unsigned    sum_u, sum_w, w, u, bias, q, r, num;
    longint             res;
    bit                 kept;
    sample_res_t        o;
    c[0] = cx; c[1] = cy; c[2] = cz;
    sum_u = 0; sum_w = 0; kept = 1'b0; res = 0;
    for (int a = 0; a < 3; a++) begin
      base[a] = c[a] >>> FRAC_BITS_DEF;
      fr[a] = c[a] & (ONE - 1);
    end
    for (int dx = 0; dx < 2; dx++)
      for (int dy = 0; dy < 2; dy++)
        for (int dz = 0; dz < 2; dz++) begin
          if (on_grid(0, base[0] + dx) && on_grid(1, base[1] + dy) &&
              on_grid(2, base[2] + dz)) begin
            kept = 1'b1;
            u = vox_mem[vox_addr(base[0] + dx, base[1] + dy, base[2] + dz, f)];
            if (vox_signed) u = u ^ 64'h8000;
            w = (dx ? fr[0] : ONE - fr[0]) * (dy ? fr[1] : ONE - fr[1]) *
                (dz ? fr[2] : ONE - fr[2]);
            sum_w += w;
            sum_u += w * u;
          end
        end
    if (kept && sum_w > 0) begin
      bias = (vox_signed ? 64'd32768 : 64'd0) * sum_w;
      num = (sum_u >= bias) ? sum_u - bias : bias - sum_u;
      q = num / sum_w;
      r = num % sum_w;
      if (r >= sum_w - r) q++;
      res = (sum_u >= bias) ? longint'(q) : -longint'(q);
    end
    o.value = res[RES_W-1:0];
    o.dom = kept;
    return o;
  endfunction

  // Offer one beat and hold it until accepted; push stays high afterwards
  task automatic send_beat(bit k, int x, int y, int z, bit f, int v,
                           bit typed = 1'b0, int ev = 0, bit ed = 1'b0);
    int          bx, by, bz;
    sample_res_t o;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    kind <= k;
    coord_x <= x[COORD_W-1:0];
    coord_y <= y[COORD_W-1:0];
    coord_z <= z[COORD_W-1:0];
    frame <= f;
    voxel_value <= v[VOX_W-1:0];
    push <= 1'b1;
    do @(posedge clk); while (full);
    sent_items++;
    bx = x >>> FRAC_BITS_DEF;
    by = y >>> FRAC_BITS_DEF;
    bz = z >>> FRAC_BITS_DEF;
    if (!k) begin
      if (on_grid(0, bx) && on_grid(1, by) && on_grid(2, bz)) begin
        vox_mem[vox_addr(bx, by, bz, f)] = v[VOX_W-1:0];
        vox_set[vox_addr(bx, by, bz, f)] = 1'b1;
      end
    end else if (typed) begin
      o.value = ev[RES_W-1:0];
      o.dom = ed;
      pending_samples.push_back(o);
    end else begin
      pending_samples.push_back(interpolate(x, y, z, f));
    end
  endtask

  // Load every in-volume neighbor that was never written, then sample
  task automatic sample_at(int x, int y, int z, bit f,
                           bit typed = 1'b0, int ev = 0, bit ed = 1'b0);
    int bx, by, bz;
    bx = x >>> FRAC_BITS_DEF;
    by = y >>> FRAC_BITS_DEF;
    bz = z >>> FRAC_BITS_DEF;
    for (int dx = 0; dx < 2; dx++)
      for (int dy = 0; dy < 2; dy++)
        for (int dz = 0; dz < 2; dz++)
          if (on_grid(0, bx + dx) && on_grid(1, by + dy) && on_grid(2, bz + dz) &&
              !vox_set[vox_addr(bx + dx, by + dy, bz + dz, f)])
            send_beat(1'b0, (bx + dx) * ONE + $urandom_range(ONE - 1),
                      (by + dy) * ONE, (bz + dz) * ONE, f, $urandom_range(65535));
    send_beat(1'b1, x, y, z, f, $urandom_range(65535), typed, ev, ed);
  endtask

  // Drop push, wait for all results, then let any trailing write finish
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic configure(int sx, int sy, int sz_, bit sgn);
    cfg_we <= 1'b1;
    cfg_index <= tvs_pkg::REG_SIZE_X;       cfg_data <= sx[SIZE_W-1:0];  @(posedge clk);
    cfg_index <= tvs_pkg::REG_SIZE_Y;       cfg_data <= sy[SIZE_W-1:0];  @(posedge clk);
    cfg_index <= tvs_pkg::REG_SIZE_Z;       cfg_data <= sz_[SIZE_W-1:0]; @(posedge clk);
    cfg_index <= tvs_pkg::REG_VOXEL_SIGNED; cfg_data <= {5'd0, sgn};     @(posedge clk);
    cfg_we <= 1'b0;
    sz[0] = sx[SIZE_W-1:0];
    sz[1] = sy[SIZE_W-1:0];
    sz[2] = sz_[SIZE_W-1:0];
    vox_signed = sgn;
  endtask

  // Coordinate near the volume: integer part from -1 to the edge, mixed fractions
  function automatic int near_coord(int a);
    int i, fr, sel;
    i = $urandom_range(0, ((eff_lim(a) > 31) ? 31 : eff_lim(a)) + 1) - 1;
    sel = $urandom_range(7);
    fr = (sel == 0) ? 0 : (sel == 1) ? ONE - 1 : $urandom_range(ONE - 1);
    return i * ONE + fr;
  endfunction

  function automatic int any_coord();
    return $urandom_range(16383) - 8192;
  endfunction

  // Result side: check each popped beat, then pick pop for the next edge
  int hold_left = 0;
  always @(posedge clk) begin
    sample_res_t o;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_samples.size() == 0) begin
          $display("%t unexpected result: value %0d domain %0d", $time, sample_value,
                   in_domain);
          errors++;
        end else begin
          o = pending_samples.pop_front();
          if (sample_value !== o.value || in_domain !== o.dom) begin
            $display("%t mismatch: expected value %0d domain %0d, got value %0d domain %0d",
                     $time, $signed(o.value), o.dom, sample_value, in_domain);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  typedef struct {
    bit k;
    int x, y, z;
    bit f;
    int v;
    bit typed;
    int ev;
    bit ed;
  } dir_row_t;

  dir_row_t dir_rows [13];

  initial begin
    int r, pc [6][4];
    int start;
    dir_rows = '{
      '{0, 0, 0, 0, 0, 16'h7FFF, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 1, 32767, 1},
      '{0, 5*ONE, 5*ONE, 5*ONE, 1, 16'h8000, 0, 0, 0},
      '{1, 5*ONE, 5*ONE, 5*ONE, 1, 0, 1, -32768, 1},
      // one voxel outside the low x edge: only zero-weight neighbors kept
      '{1, -ONE, 0, 0, 0, 0, 1, 0, 1},
      '{1, -8192, 0, 0, 0, 0, 1, 0, 0},
      '{1, 8191, 8191, 8191, 0, 0, 0, 0, 0},
      '{0, -ONE, 0, 0, 0, 16'h1234, 0, 0, 0},
      '{0, 31*ONE, 31*ONE, 31*ONE, 1, 16'hFFFF, 0, 0, 0},
      '{1, 31*ONE, 31*ONE, 31*ONE, 1, 0, 1, -1, 1},
      '{1, ONE/2, ONE/2, ONE/2, 0, 0, 0, 0, 0},
      '{0, -8192, 8191, 0, 1, 16'hAAAA, 0, 0, 0},
      '{1, 300, 77, 511, 1, 0, 0, 0, 0}
    };
    pc = '{'{32, 32, 32, 1}, '{1, 1, 1, 0}, '{0, 5, 3, 1},
           '{63, 2, 7, 0}, '{4, 4, 4, 1}, '{3, 6, 2, 0}};
    foreach (vox_set[i]) vox_set[i] = 1'b0;
    foreach (vox_mem[i]) vox_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sz[0] = 32; sz[1] = 32; sz[2] = 32; vox_signed = 1'b1;

    // Directed rows at reset settings
    foreach (dir_rows[i]) begin
      if (dir_rows[i].k)
        sample_at(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].f,
                  dir_rows[i].typed, dir_rows[i].ev, dir_rows[i].ed);
      else
        send_beat(1'b0, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].f,
                  dir_rows[i].v);
    end
    drain();

    // Random phases over several volume settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      configure(pc[p][0], pc[p][1], pc[p][2], pc[p][3]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (p == 0) hold_req = 1'b1;
      // count every beat sent, neighbor loads included
      start = sent_items;
      while (sent_items - start < PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 25)
          send_beat(1'b0, near_coord(0), near_coord(1), near_coord(2), $urandom_range(1),
                    $urandom_range(65535));
        else if (r < 30)
          send_beat(1'b0, any_coord(), any_coord(), any_coord(), $urandom_range(1),
                    $urandom_range(65535));
        else if (r < 38)
          sample_at(any_coord(), any_coord(), any_coord(), $urandom_range(1));
        else
          sample_at(near_coord(0), near_coord(1), near_coord(2), $urandom_range(1));
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS trilinear_voxel_sampler");
    end else begin
      $display("FAIL trilinear_voxel_sampler");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/tvs_pkg.sv
design/tvs_fifo.sv
design/tvs_front.sv
design/tvs_back.sv
design/trilinear_voxel_sampler.sv
design/tvs_check.sv
tb/testbench.sv
